@@ sv/lbo_pkg.sv @@
// Shared types and constants for the label boundary overlay.
// Holds field widths, register indexes, the command and result structs.
// No dependencies.
package lbo_pkg;

    localparam int LABEL_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int COLOUR_W    = 3 * CHAN_W;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = LABEL_W + COLOUR_W;
    localparam int OUT_TDATA_W = COLOUR_W + LABEL_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [CFG_W-1:0]  RESET_WIDTH   = 11'd640;
    localparam logic [CFG_W-1:0]  RESET_HEIGHT  = 11'd480;
    localparam logic [CHAN_W-1:0] BOUNDARY_RED  = 8'd255;
    localparam logic [CHAN_W-1:0] BOUNDARY_DARK = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } lbo_cfg_reg_t;

    // Per-request decision made at accept time
    typedef struct packed {
        logic go;       // request touches the line stores
        logic pixel;    // pixel request (else flush)
        logic emit;     // a result follows
        logic has_top;  // row above exists
        logic first;    // first column
        logic last;     // last column
        logic done;     // final pixel of the frame
    } lbo_cmd_t;

    typedef struct packed {
        logic                done;
        logic [LABEL_W-1:0]  numbered;
        logic                boundary;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
    } lbo_result_t;

endpackage

@@ sv/lbo_line_store.sv @@
// Line stores: middle row labels and colours, and the row above it.
// Synchronous memories with registered reads; uses lbo_pkg.
module lbo_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int LB        = 16,
    parameter int AW        = 10
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [AW-1:0]                col,
    input  logic [AW-1:0]                col_ahead,
    input  logic                         mid_we,
    input  logic [LB-1:0]                wr_label,
    input  logic [lbo_pkg::COLOUR_W-1:0] wr_colour,
    input  logic                         up_we,
    input  logic [AW-1:0]                up_col,
    input  logic [LB-1:0]                up_label,
    output logic [LB-1:0]                mid_label_rd,
    output logic [LB-1:0]                mid_ahead_rd,
    output logic [lbo_pkg::COLOUR_W-1:0] colour_rd,
    output logic [LB-1:0]                up_rd
);
    import lbo_pkg::*;

    logic [LB-1:0]       mid_label_mem [MAX_WIDTH];
    logic [COLOUR_W-1:0] colour_mem    [MAX_WIDTH];
    logic [LB-1:0]       up_mem        [MAX_WIDTH];

    logic [LB-1:0]       mid_label_reg;
    logic [LB-1:0]       mid_ahead_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [LB-1:0]       up_reg;

    // Read returns the old entry when the same column is written this cycle
    always_ff @(posedge aclk) begin
        if (mid_we) begin
            mid_label_mem[col] <= wr_label;
        end
        if (rd_en) begin
            mid_label_reg <= mid_label_mem[col];
            mid_ahead_reg <= mid_label_mem[col_ahead];
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_we) begin
            colour_mem[col] <= wr_colour;
        end
        if (rd_en) begin
            colour_reg <= colour_mem[col];
        end
    end

    always_ff @(posedge aclk) begin
        if (up_we) begin
            up_mem[up_col] <= up_label;
        end
        if (rd_en) begin
            up_reg <= up_mem[col];
        end
    end

    assign mid_label_rd = mid_label_reg;
    assign mid_ahead_rd = mid_ahead_reg;
    assign colour_rd    = colour_reg;
    assign up_rd        = up_reg;

endmodule

@@ sv/lbo_frame_ctrl.sv @@
// Frame position counters and configuration registers.
// Decides per request whether it is processed and emits; uses lbo_pkg.
module lbo_frame_ctrl #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lbo_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [lbo_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          accept,
    input  logic                          is_flush,
    output lbo_pkg::lbo_cmd_t             cmd,
    output logic [AW-1:0]                 col,
    output logic [AW-1:0]                 col_ahead
);
    import lbo_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [CFG_W-1:0] row_reg;
    logic [CFG_W-1:0] row_next;
    logic [AW-1:0]    last_col;
    logic [CFG_W-1:0] height_eff;
    logic             rows_in;

    // Zero width acts as one, oversize width saturates to the line length
    always_comb begin
        if (width_reg == '0) begin
            last_col = '0;
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            last_col = AW'(MAX_WIDTH - 1);
        end else begin
            last_col = AW'(width_reg - CFG_W'(1));
        end
    end

    assign height_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;
    assign rows_in    = (row_reg >= height_eff);

    always_comb begin
        cmd       = '0;
        cmd.first = (col_reg == '0);
        cmd.last  = (col_reg == last_col);
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            if (!is_flush) begin
                // Drop pixels that arrive once the frame is complete
                if (!rows_in) begin
                    cmd.go      = 1'b1;
                    cmd.pixel   = 1'b1;
                    cmd.emit    = (row_reg != '0);
                    cmd.has_top = (row_reg >= CFG_W'(2));
                    if (cmd.last) begin
                        col_next = '0;
                        row_next = row_reg + CFG_W'(1);
                    end else begin
                        col_next = col_reg + AW'(1);
                    end
                end
            end else if (rows_in) begin
                cmd.go      = 1'b1;
                cmd.emit    = 1'b1;
                cmd.has_top = (height_eff >= CFG_W'(2));
                cmd.done    = cmd.last;
                if (cmd.last) begin
                    col_next = '0;
                    row_next = '0;
                end else begin
                    col_next = col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we) begin
            case (lbo_cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                default:          ;
            endcase
            // Restart the frame
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col       = col_reg;
    assign col_ahead = col_reg + AW'(1);

endmodule

@@ sv/lbo_out_fifo.sv @@
// Small result queue that decouples the pipeline from output stalls.
// Register based, FIFO_DEPTH entries; uses lbo_pkg.
module lbo_out_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  lbo_pkg::lbo_result_t           push_data,
    input  logic                           out_ready,
    output logic                           out_valid,
    output lbo_pkg::lbo_result_t           out_data,
    output logic [lbo_pkg::FIFO_CNT_W-1:0] count
);
    import lbo_pkg::*;

    lbo_result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + FIFO_CNT_W'(1);
                2'b01:   count_reg <= count_reg - FIFO_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ sv/label_boundary_overlay.sv @@
// Label boundary overlay: one request per cycle while the result queue has room.
// Results leave through the line store read registers and the result queue (the result
// of a pixel comes out with the pixel one row below, or with a flush request after the
// last row). Each request makes one line store read pass, a pixel also one write pass.
// Synchronous active-low reset clears counters, queue and config to 640 x 480;
// line store contents are kept and undefined until written.
module label_boundary_overlay #(
    parameter int MAX_WIDTH  = 1024,
    parameter int LABEL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lbo_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lbo_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pixel_label[15:0], in_blue[23:16], in_green[31:24], in_red[39:32]
    input  logic [lbo_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16], numbered_label[39:24]
    output logic [lbo_pkg::OUT_TDATA_W-1:0] m_tdata,
    // is_boundary[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import lbo_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LB = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

    logic                  accept;
    lbo_cmd_t              cmd;
    logic [AW-1:0]         col;
    logic [AW-1:0]         col_ahead;
    logic [LB-1:0]         in_label;

    logic [LB-1:0]         mid_label_rd;
    logic [LB-1:0]         mid_ahead_rd;
    logic [COLOUR_W-1:0]   colour_rd;
    logic [LB-1:0]         up_rd;

    logic                  s2_valid_reg;
    lbo_cmd_t              s2_cmd_reg;
    logic [AW-1:0]         s2_col_reg;
    logic [LB-1:0]         s2_label_reg;
    logic                  s2_fwd_reg;
    logic [LB-1:0]         s2_fwd_label_reg;
    logic [LB-1:0]         prev_self_reg;

    logic [LB-1:0]         self_lab;
    logic [LB-1:0]         top_lab;
    logic [LB-1:0]         bottom_lab;
    logic [LB-1:0]         left_lab;
    logic [LB-1:0]         right_lab;
    logic                  boundary;
    lbo_result_t           result;
    logic                  push;
    lbo_result_t           out_data;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // Keep room in the queue for everything already in flight
    assign s_tready = ({1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s2_valid_reg})
                      < (FIFO_CNT_W + 1)'(FIFO_DEPTH - 1);
    assign accept   = s_tvalid && s_tready;
    assign in_label = s_tdata[LB-1:0];

    lbo_frame_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .is_flush  (s_tuser),
        .cmd       (cmd),
        .col       (col),
        .col_ahead (col_ahead)
    );

    lbo_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .LB        (LB),
        .AW        (AW)
    ) u_store (
        .aclk         (aclk),
        .rd_en        (cmd.go),
        .col          (col),
        .col_ahead    (col_ahead),
        .mid_we       (cmd.go && cmd.pixel),
        .wr_label     (in_label),
        .wr_colour    (s_tdata[LABEL_W +: COLOUR_W]),
        .up_we        (s2_valid_reg && s2_cmd_reg.pixel),
        .up_col       (s2_col_reg),
        .up_label     (self_lab),
        .mid_label_rd (mid_label_rd),
        .mid_ahead_rd (mid_ahead_rd),
        .colour_rd    (colour_rd),
        .up_rd        (up_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= cmd.go;
        end
    end

    // Forward the row-above entry when the previous request writes it this cycle
    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            s2_cmd_reg       <= cmd;
            s2_col_reg       <= col;
            s2_label_reg     <= in_label;
            s2_fwd_reg       <= s2_valid_reg && s2_cmd_reg.pixel && (s2_col_reg == col);
            s2_fwd_label_reg <= mid_label_rd;
        end
        if (s2_valid_reg) begin
            prev_self_reg <= self_lab;
        end
    end

    // Left neighbour is the middle-row label of the previous column
    assign self_lab   = mid_label_rd;
    assign top_lab    = !s2_cmd_reg.has_top ? self_lab :
                        (s2_fwd_reg ? s2_fwd_label_reg : up_rd);
    assign bottom_lab = s2_cmd_reg.pixel ? s2_label_reg : self_lab;
    assign left_lab   = s2_cmd_reg.first ? self_lab : prev_self_reg;
    assign right_lab  = s2_cmd_reg.last ? self_lab : mid_ahead_rd;
    assign boundary   = (top_lab != self_lab) || (bottom_lab != self_lab)
                        || (left_lab != self_lab) || (right_lab != self_lab);

    always_comb begin
        result.done     = s2_cmd_reg.done;
        result.numbered = LABEL_W'(self_lab) + LABEL_W'(1);
        result.boundary = boundary;
        result.red      = boundary ? BOUNDARY_RED  : colour_rd[2*CHAN_W +: CHAN_W];
        result.green    = boundary ? BOUNDARY_DARK : colour_rd[CHAN_W +: CHAN_W];
        result.blue     = boundary ? BOUNDARY_DARK : colour_rd[0 +: CHAN_W];
    end

    assign push = s2_valid_reg && s2_cmd_reg.emit;

    lbo_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata = {out_data.numbered, out_data.red, out_data.green, out_data.blue};
    assign m_tuser = out_data.boundary;
    assign m_tlast = out_data.done;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for label_boundary_overlay: streams label maps with colours,
// predicts the boundary overlay one row late and checks every result field.
// Depends on lbo_pkg and the label_boundary_overlay RTL.
`timescale 1ns / 100ps

module tb_top;
    import lbo_pkg::*;

    localparam int LINE_MAX       = 1024;
    localparam int HOLD_OFF       = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 250;
    localparam int MAX_REPORTS    = 10;
    localparam int LINE_DRAIN     = 8;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic               boundary;
        logic [LABEL_W-1:0] numbered;
        logic               done;
    } overlay_px_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Shadow of the block's line stores, counters and registers
    logic [LABEL_W-1:0]  upper_lbl [LINE_MAX];
    logic [LABEL_W-1:0]  middle_lbl [LINE_MAX];
    logic [COLOUR_W-1:0] middle_bgr [LINE_MAX];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [CFG_W-1:0]    frame_w_reg;
    logic [CFG_W-1:0]    frame_h_reg;

    overlay_px_t pending_pixels[$];
    int          mismatch_cnt;
    int          src_idle_pct;
    int          sink_stall_pct;

    label_boundary_overlay i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic overlay_px_t mark_pixel(input logic [LABEL_W-1:0] self,
                                               input logic [LABEL_W-1:0] top,
                                               input logic [LABEL_W-1:0] bottom,
                                               input logic [LABEL_W-1:0] left,
                                               input logic [LABEL_W-1:0] right,
                                               input logic [COLOUR_W-1:0] bgr,
                                               input logic done);
        overlay_px_t px;
        px.boundary = (self != top) || (self != bottom) || (self != left) || (self != right);
        px.blue     = px.boundary ? 8'd0 : bgr[7:0];
        px.green    = px.boundary ? 8'd0 : bgr[15:8];
        px.red      = px.boundary ? 8'd255 : bgr[23:16];
        px.numbered = self + 16'd1;
        px.done     = done;
        return px;
    endfunction

    // Append one expected result at the tail of the queue
    task automatic expect_result(input overlay_px_t px);
        pending_pixels = {pending_pixels, px};
    endtask

    // Advance the shadow state by one accepted request, queue any result it releases
    task automatic predict_overlay(input req_kind_t kind, input logic [LABEL_W-1:0] lbl,
                                   input logic [COLOUR_W-1:0] bgr);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        logic [LABEL_W-1:0] self;
        logic [LABEL_W-1:0] top;
        logic [LABEL_W-1:0] left;
        logic [LABEL_W-1:0] right;
        logic               done;
        w = (frame_w_reg == 0) ? 1 : ((frame_w_reg > LINE_MAX) ? LINE_MAX : frame_w_reg);
        h = (frame_h_reg == 0) ? 1 : frame_h_reg;
        c = (col_pos >= w) ? 0 : col_pos;
        if (kind == REQ_PIXEL) begin
            if (row_pos >= h) return;
            if (row_pos >= 1) begin
                self  = middle_lbl[c];
                top   = (row_pos >= 2) ? upper_lbl[c] : self;
                // upper store one column back already holds the middle row there
                left  = (c > 0) ? upper_lbl[c-1] : self;
                right = (c + 1 < w) ? middle_lbl[c+1] : self;
                expect_result(mark_pixel(self, top, lbl, left, right, middle_bgr[c], 1'b0));
            end
            upper_lbl[c]  = middle_lbl[c];
            middle_lbl[c] = lbl;
            middle_bgr[c] = bgr;
            c++;
            if (c >= w) begin
                c = 0;
                row_pos++;
            end
            col_pos = c;
        end else begin
            if (row_pos < h) return;
            self  = middle_lbl[c];
            top   = (h >= 2) ? upper_lbl[c] : self;
            left  = (c > 0) ? middle_lbl[c-1] : self;
            right = (c + 1 < w) ? middle_lbl[c+1] : self;
            done  = (c + 1 >= w);
            expect_result(mark_pixel(self, top, self, left, right, middle_bgr[c], done));
            c++;
            if (done) begin
                c = 0;
                row_pos = 0;
            end
            col_pos = c;
        end
    endtask

    task automatic send_req(input req_kind_t kind, input logic [LABEL_W-1:0] lbl,
                            input logic [COLOUR_W-1:0] bgr);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {bgr, lbl};
        do @(posedge aclk); while (!s_tready);
        predict_overlay(kind, lbl, bgr);
    endtask

    // Drop valid and hold until every pending result is out and the pipe is quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic write_reg(input lbo_cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH) frame_w_reg = val;
        else frame_h_reg = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
            default: begin src_idle_pct = 14; sink_stall_pct = 14; end
        endcase
    endtask

    // One frame of blocky regions; noisy frames add ignored requests and may stop early
    task automatic send_frame(input int w, input int h, input bit noisy,
                              inout int sent, output bit complete);
        int                 bw;
        int                 bh;
        int                 cut;
        logic [LABEL_W-1:0] base;
        logic [LABEL_W-1:0] lbl;
        bw   = $urandom_range(1, 4);
        bh   = $urandom_range(1, 4);
        base = LABEL_W'($urandom);
        cut  = (noisy && $urandom_range(0, 9) == 0) ? $urandom_range(0, w * h - 1) : w * h;
        for (int i = 0; i < cut; i++) begin
            if (noisy && $urandom_range(0, 29) == 0) begin
                send_req(REQ_FLUSH, LABEL_W'($urandom), COLOUR_W'($urandom));
            end
            lbl = base + 16'(((i % w) / bw) * 40503 + ((i / w) / bh) * 9973);
            if ($urandom_range(0, 11) == 0) lbl = LABEL_W'($urandom);
            send_req(REQ_PIXEL, lbl, COLOUR_W'($urandom));
            sent++;
        end
        complete = (cut == w * h);
        if (!complete) return;
        for (int c = 0; c < w; c++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_req(REQ_PIXEL, LABEL_W'($urandom), COLOUR_W'($urandom));
            end
            send_req(REQ_FLUSH, LABEL_W'($urandom), COLOUR_W'($urandom));
            sent++;
        end
    endtask

    // 3x3 frame with extreme colours and label wrap, then a single-pixel frame
    task automatic test_directed();
        logic [LABEL_W-1:0] lbls [9] = '{16'd5, 16'd5, 16'd5,
                                         16'd5, 16'd5, 16'hFFFF,
                                         16'd0, 16'd5, 16'd5};
        logic [COLOUR_W-1:0] bgr;
        set_idle(3);
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        send_req(REQ_FLUSH, 16'hFFFF, 24'hFFFFFF);
        for (int i = 0; i < 9; i++) begin
            bgr = (i == 0) ? 24'h000000 : ((i == 1) ? 24'hFFFFFF : 24'($urandom));
            send_req(REQ_PIXEL, lbls[i], bgr);
        end
        send_req(REQ_PIXEL, 16'h1234, 24'h00FF00);
        for (int c = 0; c < 3; c++) send_req(REQ_FLUSH, 16'h0000, 24'h000000);
        settle();
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        send_req(REQ_PIXEL, 16'hFFFF, COLOUR_W'($urandom));
        send_req(REQ_FLUSH, 16'h0000, COLOUR_W'($urandom));
        send_req(REQ_PIXEL, 16'h0000, COLOUR_W'($urandom));
        send_req(REQ_FLUSH, 16'hFFFF, COLOUR_W'($urandom));
    endtask

    // Zero and oversize registers, a saturated full-width line and a tall column
    task automatic test_size_extremes();
        logic [CFG_W-1:0] reg_w [4] = '{11'd0, 11'd2047, 11'd1, 11'd2};
        logic [CFG_W-1:0] reg_h [4] = '{11'd2, 11'd0, 11'd40, 11'd3};
        int               eff_w [4] = '{1, 1024, 1, 2};
        int               eff_h [4] = '{2, 1, 40, 3};
        int               sent;
        bit               complete;
        sent = 0;
        for (int k = 0; k < 4; k++) begin
            set_idle(k);
            settle();
            write_reg(REG_FRAME_WIDTH, reg_w[k]);
            write_reg(REG_FRAME_HEIGHT, reg_h[k]);
            if (eff_w[k] == LINE_MAX) begin
                // Fill the whole line, then drain only its first columns
                for (int i = 0; i < LINE_MAX; i++) begin
                    send_req(REQ_PIXEL, LABEL_W'(i / 3), COLOUR_W'($urandom));
                end
                for (int c = 0; c < LINE_DRAIN; c++) send_req(REQ_FLUSH, '0, '0);
            end else begin
                send_frame(eff_w[k], eff_h[k], 1'b0, sent, complete);
            end
        end
    endtask

    task automatic test_random_frames();
        int sent;
        int grp;
        int w;
        int h;
        int frames;
        bit complete;
        sent = 0;
        grp  = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idle(grp % 4);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 8);
            settle();
            write_reg(REG_FRAME_WIDTH, CFG_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                send_frame(w, h, 1'b1, sent, complete);
                if (!complete || sent >= RANDOM_ITEMS) break;
                if ($urandom_range(0, 19) == 0) settle();
            end
            grp++;
        end
    endtask

    task automatic flag_mismatch(input string what, input overlay_px_t want,
                                 input overlay_px_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: %s: exp b=%0d g=%0d r=%0d bnd=%0b lbl=%0d done=%0b", $realtime,
                     what, want.blue, want.green, want.red, want.boundary, want.numbered,
                     want.done);
            $display("%0t: %s: got b=%0d g=%0d r=%0d bnd=%0b lbl=%0d done=%0b", $realtime,
                     what, got.blue, got.green, got.red, got.boundary, got.numbered,
                     got.done);
        end
    endtask

    always @(posedge aclk) begin : check_results
        overlay_px_t got;
        overlay_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.blue     = m_tdata[7:0];
            got.green    = m_tdata[15:8];
            got.red      = m_tdata[23:16];
            got.numbered = m_tdata[39:24];
            got.boundary = m_tuser;
            got.done     = m_tlast;
            if (pending_pixels.size() == 0) begin
                flag_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.blue != want.blue || got.green != want.green ||
                    got.red != want.red || got.boundary != want.boundary ||
                    got.numbered != want.numbered || got.done != want.done) begin
                    flag_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        mismatch_cnt   = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        col_pos        = 0;
        row_pos        = 0;
        frame_w_reg    = RESET_WIDTH;
        frame_h_reg    = RESET_HEIGHT;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_size_extremes();
        test_random_frames();

        settle();
        repeat (10) @(posedge aclk);
        if (pending_pixels.size() != 0) begin
            mismatch_cnt++;
            $display("%0d results never arrived", pending_pixels.size());
        end
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lbo_pkg.sv
sv/lbo_line_store.sv
sv/lbo_frame_ctrl.sv
sv/lbo_out_fifo.sv
sv/label_boundary_overlay.sv
dv/tb_top.sv
